[design/pidaw_pkg.sv]
// pidaw_pkg: shared constants, types and codes for the PID controller block.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package pidaw_pkg;

    localparam int DATA_W  = 16;
    localparam int FRAC_W  = 16;
    localparam int ERR_W   = DATA_W + 1;
    localparam int ESUM_W  = DATA_W + 2;
    localparam int STATE_W = 48;
    localparam int ACC_W   = 68;
    localparam int MPLR_W  = 18;
    localparam int DEN_W   = 18;
    localparam int WIDE_W  = 56;
    localparam int PROD_W  = 34;
    localparam int CNT_W   = 7;
    localparam int IDX_W   = 3;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [IDX_W-1:0]         cfg_idx_t;

    localparam cfg_idx_t REG_KP          = 3'd0;
    localparam cfg_idx_t REG_KI          = 3'd1;
    localparam cfg_idx_t REG_KD          = 3'd2;
    localparam cfg_idx_t REG_SAMPLE_TIME = 3'd3;
    localparam cfg_idx_t REG_FILTER_TAU  = 3'd4;
    localparam cfg_idx_t REG_LIMIT_MIN   = 3'd5;
    localparam cfg_idx_t REG_LIMIT_MAX   = 3'd6;

    localparam logic signed [WIDE_W-1:0] WIDE_STATE_MAX =
        {{(WIDE_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] WIDE_STATE_MIN = ~WIDE_STATE_MAX;
    localparam logic signed [ACC_W-1:0] ACC_STATE_MAX =
        {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_STATE_MIN = ~ACC_STATE_MAX;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL_P,
        ST_MUL_KI,
        ST_MUL_KT,
        ST_INT,
        ST_MUL_KD,
        ST_MUL_CD,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

[design/pidaw_if.sv]
// pidaw_if: valid/ready stream interfaces for sample input and drive output words.
// Depends on pidaw_pkg.
`timescale 1ns / 1ps

interface pidaw_in_if;
    import pidaw_pkg::*;
    logic  valid;
    logic  ready;
    data_t target;
    data_t measured;

    modport source (output valid, output target, output measured, input ready);
    modport sink (input valid, input target, input measured, output ready);
endinterface

interface pidaw_out_if;
    import pidaw_pkg::*;
    logic  valid;
    logic  ready;
    data_t drive;

    modport source (output valid, output drive, input ready);
    modport sink (input valid, input drive, output ready);
endinterface

[design/pidaw_serial_mul.sv]
// pidaw_serial_mul: signed shift-add multiplier, one multiplier bit per cycle.
// Depends on pidaw_pkg.
`timescale 1ns / 1ps

module pidaw_serial_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [pidaw_pkg::ACC_W-1:0]  mcand,
    input  logic signed [pidaw_pkg::MPLR_W-1:0] mplier,
    output logic                                done,
    output logic signed [pidaw_pkg::ACC_W-1:0]  product
);
    import pidaw_pkg::*;

    logic signed [ACC_W-1:0] mcand_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [MPLR_W-1:0]       mplier_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic signed [ACC_W-1:0] addend;
    logic                    last;

    always_comb
    begin
        last   = (cnt_reg == CNT_W'(MPLR_W - 1));
        addend = '0;
        if (mplier_reg[0])
        begin
            // sign bit of the multiplier carries negative weight
            addend = last ? -mcand_reg : mcand_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_reg + addend;
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[design/pidaw_serial_div.sv]
// pidaw_serial_div: restoring divider, signed dividend by positive divisor, floor result.
// One quotient bit per cycle. Depends on pidaw_pkg.
`timescale 1ns / 1ps

module pidaw_serial_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [pidaw_pkg::ACC_W-1:0] num,
    input  logic [pidaw_pkg::DEN_W-1:0]        den,
    output logic                               done,
    output logic signed [pidaw_pkg::ACC_W-1:0] quot
);
    import pidaw_pkg::*;

    logic [ACC_W-1:0] m_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic             last;

    always_comb
    begin
        shifted = {rem_reg, m_reg[ACC_W-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = (shifted >= {1'b0, den_reg});
        last    = (cnt_reg == CNT_W'(ACC_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // negative dividend: floor(n/d) = ~floor(~n/d)
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[ACC_W-1];
            m_reg   <= num[ACC_W-1] ? ~num : num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            m_reg   <= {m_reg[ACC_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? signed'(~m_reg) : signed'(m_reg);

endmodule

[design/pid_controller_antiwindup_core.sv]
// pid_controller_antiwindup_core: PID controller, trapezoid integrator with
// anti-windup clamp, filtered derivative on measurement.
// Usage:
//   din  (valid/ready) carries one sample word: target and measured.
//   dout (valid/ready) carries one drive word per sample.
//   cfg_we/cfg_idx/cfg_data write gains, sample time, tau and limits;
//   write only while no sample is in flight. Unknown indexes are ignored.
// Steps from sample accept to drive valid: load, five serial multiplies
//   of 18 steps each on one shared shift-add unit, the integrator update,
//   a 68-step restoring divide for the derivative filter, then the output
//   step.
// One sample at a time: din.ready is high only while idle, so no new
//   sample is taken until the current one has left its output step.
// The drive sits in an output register, so a new sample is taken while a
//   finished drive still waits; if dout stalls, the next sample holds at
//   its final step until the register frees.
// Reset: all gains and state cleared, sample time 1.0, limits full range.
// Depends on pidaw_pkg, pidaw_if, pidaw_serial_mul, pidaw_serial_div.
`timescale 1ns / 1ps

module pid_controller_antiwindup_core (
    input  logic                            clk,
    input  logic                            rst_n,
    pidaw_in_if.sink                        din,
    pidaw_out_if.source                     dout,
    input  logic                            cfg_we,
    input  logic [pidaw_pkg::IDX_W-1:0]     cfg_idx,
    input  logic [pidaw_pkg::DATA_W-1:0]    cfg_data
);
    import pidaw_pkg::*;

    state_t state_reg, state_next;

    data_t             kp_reg, ki_reg, kd_reg, limit_min_reg, limit_max_reg;
    logic [DATA_W-1:0] sample_time_reg, filter_tau_reg;

    logic signed [ERR_W-1:0]   e_reg;
    logic signed [ESUM_W-1:0]  esum_reg;
    logic signed [ERR_W-1:0]   dm_reg;
    data_t                     measured_reg;
    logic signed [WIDE_W-1:0]  p_reg;
    logic signed [PROD_W-1:0]  kdm_reg;
    logic signed [STATE_W-1:0] integrator_reg;
    logic signed [STATE_W-1:0] fd_reg;
    logic signed [ERR_W-1:0]   last_error_reg;
    data_t                     last_measured_reg;
    logic                      dout_valid_reg;
    data_t                     drive_reg;

    logic                      mul_start, mul_done;
    logic signed [ACC_W-1:0]   mul_mcand, mul_product;
    logic signed [MPLR_W-1:0]  mul_mplier;
    logic                      div_start, div_done;
    logic signed [ACC_W-1:0]   div_num, div_quot;
    logic [DEN_W-1:0]          den;
    logic signed [MPLR_W-1:0]  c_coef;
    logic                      out_free;

    logic signed [WIDE_W-1:0]  ii, lmax, lmin, hi, lo, ii_sat;
    logic signed [STATE_W-1:0] fd_new;
    logic signed [WIDE_W-1:0]  sum, y;
    data_t                     drive_new;

    pidaw_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .product (mul_product)
    );

    pidaw_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign din.ready  = (state_reg == ST_IDLE);
    assign dout.valid = dout_valid_reg;
    assign dout.drive = drive_reg;
    assign out_free   = !dout_valid_reg || dout.ready;

    always_comb
    begin
        den     = DEN_W'({filter_tau_reg, 1'b0}) + DEN_W'(sample_time_reg);
        c_coef  = signed'({2'b00, sample_time_reg}) - signed'({1'b0, filter_tau_reg, 1'b0});
        // dividend = c*fd - 2*kd*dm*2^F
        div_num = mul_product - (ACC_W'(kdm_reg) <<< (FRAC_W + 1));
    end

    // integrator update with anti-windup clamp
    always_comb
    begin
        ii   = WIDE_W'(integrator_reg) + WIDE_W'(mul_product >>> (17 - FRAC_W));
        lmax = WIDE_W'(limit_max_reg) <<< FRAC_W;
        lmin = WIDE_W'(limit_min_reg) <<< FRAC_W;
        hi   = (lmax > p_reg) ? lmax - p_reg : '0;
        lo   = (lmin < p_reg) ? lmin - p_reg : '0;
        if (ii > hi)
        begin
            ii = hi;
        end
        else if (ii < lo)
        begin
            ii = lo;
        end
        if (ii > WIDE_STATE_MAX)
        begin
            ii_sat = WIDE_STATE_MAX;
        end
        else if (ii < WIDE_STATE_MIN)
        begin
            ii_sat = WIDE_STATE_MIN;
        end
        else
        begin
            ii_sat = ii;
        end
    end

    // derivative result and final drive
    always_comb
    begin
        if (den == '0)
        begin
            fd_new = '0;
        end
        else if (div_quot > ACC_STATE_MAX)
        begin
            fd_new = STATE_W'(ACC_STATE_MAX);
        end
        else if (div_quot < ACC_STATE_MIN)
        begin
            fd_new = STATE_W'(ACC_STATE_MIN);
        end
        else
        begin
            fd_new = STATE_W'(div_quot);
        end
        sum = p_reg + WIDE_W'(integrator_reg) + WIDE_W'(fd_new);
        y   = sum >>> FRAC_W;
        if (sum[WIDE_W-1] && (sum[FRAC_W-1:0] != '0))
        begin
            y = y + WIDE_W'(1);
        end
        if (y > WIDE_W'(limit_max_reg))
        begin
            drive_new = limit_max_reg;
        end
        else if (y < WIDE_W'(limit_min_reg))
        begin
            drive_new = limit_min_reg;
        end
        else
        begin
            drive_new = y[DATA_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_mcand  = '0;
        mul_mplier = '0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (din.valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_MUL_P;
                mul_start  = 1'b1;
                mul_mcand  = ACC_W'(kp_reg);
                mul_mplier = MPLR_W'(e_reg);
            end
            ST_MUL_P:
            begin
                if (mul_done)
                begin
                    state_next = ST_MUL_KI;
                    mul_start  = 1'b1;
                    mul_mcand  = ACC_W'(ki_reg);
                    mul_mplier = esum_reg;
                end
            end
            ST_MUL_KI:
            begin
                if (mul_done)
                begin
                    state_next = ST_MUL_KT;
                    mul_start  = 1'b1;
                    mul_mcand  = mul_product;
                    mul_mplier = signed'({2'b00, sample_time_reg});
                end
            end
            ST_MUL_KT:
            begin
                if (mul_done)
                begin
                    state_next = ST_INT;
                end
            end
            ST_INT:
            begin
                state_next = ST_MUL_KD;
                mul_start  = 1'b1;
                mul_mcand  = ACC_W'(kd_reg);
                mul_mplier = MPLR_W'(dm_reg);
            end
            ST_MUL_KD:
            begin
                if (mul_done)
                begin
                    state_next = ST_MUL_CD;
                    mul_start  = 1'b1;
                    mul_mcand  = ACC_W'(fd_reg);
                    mul_mplier = c_coef;
                end
            end
            ST_MUL_CD:
            begin
                if (mul_done)
                begin
                    state_next = ST_DIV;
                    div_start  = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg          <= '0;
            ki_reg          <= '0;
            kd_reg          <= '0;
            sample_time_reg <= DATA_W'(256);
            filter_tau_reg  <= '0;
            limit_min_reg   <= signed'({1'b1, {(DATA_W-1){1'b0}}});
            limit_max_reg   <= signed'({1'b0, {(DATA_W-1){1'b1}}});
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_KP:          kp_reg          <= signed'(cfg_data);
                REG_KI:          ki_reg          <= signed'(cfg_data);
                REG_KD:          kd_reg          <= signed'(cfg_data);
                REG_SAMPLE_TIME: sample_time_reg <= cfg_data;
                REG_FILTER_TAU:  filter_tau_reg  <= cfg_data;
                REG_LIMIT_MIN:   limit_min_reg   <= signed'(cfg_data);
                REG_LIMIT_MAX:   limit_max_reg   <= signed'(cfg_data);
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integrator_reg    <= '0;
            fd_reg            <= '0;
            last_error_reg    <= '0;
            last_measured_reg <= '0;
            dout_valid_reg    <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_INT)
            begin
                integrator_reg <= STATE_W'(ii_sat);
            end
            if ((state_reg == ST_OUT) && out_free)
            begin
                fd_reg            <= fd_new;
                last_error_reg    <= e_reg;
                last_measured_reg <= measured_reg;
                dout_valid_reg    <= 1'b1;
            end
            else if (dout.ready)
            begin
                dout_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && din.valid)
        begin
            measured_reg <= din.measured;
            e_reg        <= ERR_W'(din.target) - ERR_W'(din.measured);
            esum_reg     <= ESUM_W'(ERR_W'(din.target) - ERR_W'(din.measured))
                            + ESUM_W'(last_error_reg);
            dm_reg       <= ERR_W'(din.measured) - ERR_W'(last_measured_reg);
        end
        if ((state_reg == ST_MUL_P) && mul_done)
        begin
            p_reg <= WIDE_W'(signed'(mul_product[PROD_W-1:0])) <<< (FRAC_W - 8);
        end
        if ((state_reg == ST_MUL_KD) && mul_done)
        begin
            kdm_reg <= signed'(mul_product[PROD_W-1:0]);
        end
        if ((state_reg == ST_OUT) && out_free)
        begin
            drive_reg <= drive_new;
        end
    end

endmodule

[design/pidaw_checker.sv]
// pidaw_checker: port-level assertions for the PID controller, bound to the top level.
// Depends on pid_controller_antiwindup_core.
`timescale 1ns / 1ps

module pidaw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        din_valid,
    input logic        din_ready,
    input logic        dout_valid,
    input logic        dout_ready,
    input logic [15:0] dout_drive
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout_ready |=> dout_valid && $stable(dout_drive))
        else $error("drive word changed while stalled");

    // one sample at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        din_valid && din_ready |=> !din_ready)
        else $error("input still ready after a sample was taken");

    // a new drive appears only as the block returns to idle
    a_rise_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dout_valid) |-> din_ready)
        else $error("drive posted while sample still in work");

    // idle waits for a sample
    a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
        din_ready && !din_valid |=> din_ready)
        else $error("left idle without a sample");

endmodule

bind pid_controller_antiwindup_core pidaw_checker u_pidaw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .din_valid  (din.valid),
    .din_ready  (din.ready),
    .dout_valid (dout.valid),
    .dout_ready (dout.ready),
    .dout_drive (dout.drive)
);
